/* design/glsl_pkg.sv */
// ----------------------------------------------------------------------------
// glsl_pkg
// Shared widths, types and the integer exponential table of the grid
// likelihood source locator.
// ----------------------------------------------------------------------------
package glsl_pkg;

  localparam int unsigned DIM_W    = 7;   // grid dimension register width
  localparam int unsigned DIV_NW   = 49;  // divider numerator / quotient width
  localparam int unsigned DIV_DW   = 33;  // divider denominator width
  localparam int unsigned SQ_W     = 34;  // square root radicand width
  localparam int unsigned ROOT_W   = 18;  // square root result width
  localparam int unsigned MUL_W    = 25;  // shared multiplier operand width
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned SERIES_N = 11;  // last term of the exp(-f) series
  localparam int unsigned EXP_N    = 12;  // integer steps covered by the table

  localparam logic [0:0] CFG_GRID_COLUMNS = 1'b0;
  localparam logic [0:0] CFG_GRID_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_COMPUTE = 2'd1,
    MODE_READ    = 2'd2,
    MODE_ARGMAX  = 2'd3
  } mode_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        rng;
    logic [15:0]        spr;
  } sensor_t;

  // exp(-n) in Q1.24
  function automatic logic [24:0] exp_int_q24(input logic [3:0] n);
    logic [24:0] v;
    unique case (n)
      4'd0:    v = 25'd16777216;
      4'd1:    v = 25'd6171993;
      4'd2:    v = 25'd2270549;
      4'd3:    v = 25'd835288;
      4'd4:    v = 25'd307285;
      4'd5:    v = 25'd113044;
      4'd6:    v = 25'd41587;
      4'd7:    v = 25'd15299;
      4'd8:    v = 25'd5628;
      4'd9:    v = 25'd2070;
      4'd10:   v = 25'd762;
      4'd11:   v = 25'd280;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

  // ceil(2^(24+l) / k) with l = ceil(log2 k); exact floor(x / k) for x < 2^24
  function automatic logic [24:0] recip_mul(input logic [3:0] k);
    logic [24:0] v;
    unique case (k)
      4'd1:    v = 25'd16777216;
      4'd2:    v = 25'd16777216;
      4'd3:    v = 25'd22369622;
      4'd4:    v = 25'd16777216;
      4'd5:    v = 25'd26843546;
      4'd6:    v = 25'd22369622;
      4'd7:    v = 25'd19173962;
      4'd8:    v = 25'd16777216;
      4'd9:    v = 25'd29826162;
      4'd10:   v = 25'd26843546;
      4'd11:   v = 25'd24403224;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

  // extra shift l above 24 for the reciprocal of k
  function automatic logic [2:0] recip_shift(input logic [3:0] k);
    logic [2:0] v;
    unique case (k)
      4'd1:    v = 3'd0;
      4'd2:    v = 3'd1;
      4'd3:    v = 3'd2;
      4'd4:    v = 3'd2;
      4'd5:    v = 3'd3;
      4'd6:    v = 3'd3;
      4'd7:    v = 3'd3;
      4'd8:    v = 3'd3;
      4'd9:    v = 3'd4;
      4'd10:   v = 3'd4;
      4'd11:   v = 3'd4;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/glsl_ram.sv */
// ----------------------------------------------------------------------------
// glsl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module glsl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/glsl_div.sv */
// ----------------------------------------------------------------------------
// glsl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module glsl_div
  import glsl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quot_o
);

  logic [DIV_DW:0]   rem_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] den_q;
  logic [5:0]        cnt_q;
  logic              busy_q, done_q;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[DIV_NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* design/glsl_sqrt.sv */
// ----------------------------------------------------------------------------
// glsl_sqrt
// Digit-by-digit integer square root, rounded down, one bit per cycle.
// ----------------------------------------------------------------------------
module glsl_sqrt
  import glsl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQ_W:0] v_q, r_q, b_q;
  logic          busy_q, done_q;
  logic [SQ_W:0] rb;
  logic          take;

  assign rb   = r_q + b_q;
  assign take = v_q >= rb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && b_q == (SQ_W+1)'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= {1'b0, rad_i};
      r_q <= '0;
      b_q <= (SQ_W+1)'(1) << SQ_W;
    end else if (busy_q) begin
      if (take) begin
        v_q <= v_q - rb;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

/* design/grid_likelihood_source_locator.sv */
// ----------------------------------------------------------------------------
// grid_likelihood_source_locator
// Grid maximum-likelihood multilateration with a shared multiplier, an
// iterative square root and an iterative divider under one sequencer.
//
//   port group   direction  handshake
//   request      in         start_i high while busy_o low
//   result       out        result_valid_o strobe, one cycle, no back-pressure
//   config       in         cfg_we_i, taken at every edge it is high
//
// Load sensor and argmax report are done from idle without raising busy_o.
// Compute row is dominated per sensor by the 18-step square root and the
// 49-step divider. Read row runs per cell eleven series terms (a multiply,
// then a reciprocal multiply for the division by the term index), skipped
// when the probability saturates. busy_o is high while a row is worked on.
// Reset clears the sensor count and peak and sets both grid registers to 64;
// the stores hold no reset value.
// ----------------------------------------------------------------------------
module grid_likelihood_source_locator
  import glsl_pkg::*;
#(
  parameter int unsigned MAX_SENSORS = 16,
  parameter int unsigned GRID_SIDE   = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] sensor_x_i,
  input  logic signed [15:0] sensor_y_i,
  input  logic [15:0]        sensor_range_i,
  input  logic [15:0]        sensor_spread_i,
  input  logic               first_sensor_i,
  input  logic [5:0]         row_i,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic               kind_o,
  output logic [5:0]         column_o,
  output logic [5:0]         row_index_o,
  output logic [16:0]        probability_o,
  output logic signed [31:0] peak_log_o,
  output logic               last_o
);

  localparam int unsigned SA_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SENSORS + 1);
  localparam int unsigned LOG_D  = GRID_SIDE * GRID_SIDE;
  localparam int unsigned LOG_AW = $clog2(LOG_D);

  typedef enum logic [4:0] {
    S_IDLE, C_CELL, C_RD, C_DX, C_DY, C_SQ, C_SQW, C_AD, C_SP, C_DIV, C_DIVW,
    C_WR, N_RD, N_EVAL, N_MUL, N_QX, N_RCP, N_ACC, N_FIN, N_RND, N_OUT
  } state_e;

  state_e state_q;

  logic [DIM_W-1:0] grid_columns_q, grid_rows_q, cols, rows;
  logic [CNT_W-1:0] count_q, s_q;
  logic [DIM_W-1:0] col_q;
  logic [5:0]       row_q;
  logic signed [31:0] peak_q;
  logic [5:0]       peak_col_q, peak_row_q;

  logic [31:0]        mag_q;
  logic [PROD_W-1:0]  prod_q;
  logic [31:0]        dx2_q;
  logic [32:0]        ad2_q;
  logic [ROOT_W-1:0]  d_q;
  logic [24:0]        t_q, acc_q;
  logic [23:0]        f_q;
  logic [3:0]         n_q, k_q;
  logic [16:0]        prob_q;

  logic               res_valid_q, kind_q, last_q;
  logic [5:0]         res_col_q, res_row_q;
  logic [16:0]        res_prob_q;
  logic signed [31:0] res_peak_q;

  // ---- configuration --------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= DIM_W'(64);
      grid_rows_q    <= DIM_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_COLUMNS: grid_columns_q <= cfg_data_i;
        CFG_GRID_ROWS:    grid_rows_q    <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  always_comb begin
    priority if (grid_columns_q == '0)                  cols = DIM_W'(1);
    else if (grid_columns_q > DIM_W'(GRID_SIDE))        cols = DIM_W'(GRID_SIDE);
    else                                                cols = grid_columns_q;
    priority if (grid_rows_q == '0)                     rows = DIM_W'(1);
    else if (grid_rows_q > DIM_W'(GRID_SIDE))           rows = DIM_W'(GRID_SIDE);
    else                                                rows = grid_rows_q;
  end

  // ---- stores ---------------------------------------------------------------
  logic              sen_we;
  sensor_t           sen_wdata, sen_rd;
  logic [63:0]       sen_rdata;
  logic              accept, load_ok;
  logic [LOG_AW-1:0] cell_addr;
  logic [31:0]       log_rdata, log_wdata;

  assign accept  = start_i && (state_q == S_IDLE);
  assign load_ok = first_sensor_i || (count_q < CNT_W'(MAX_SENSORS));
  assign sen_we  = accept && (mode_e'(mode_i) == MODE_LOAD) && load_ok;

  always_comb begin
    sen_wdata.x   = sensor_x_i;
    sen_wdata.y   = sensor_y_i;
    sen_wdata.rng = sensor_range_i;
    sen_wdata.spr = (sensor_spread_i == 16'd0) ? 16'd1 : sensor_spread_i;
  end

  glsl_ram #(.WIDTH(64), .DEPTH(MAX_SENSORS)) u_sensor_ram (
    .clk_i   (clk_i),
    .we_i    (sen_we),
    .waddr_i (first_sensor_i ? SA_W'(0) : count_q[SA_W-1:0]),
    .wdata_i (sen_wdata),
    .raddr_i (s_q[SA_W-1:0]),
    .rdata_o (sen_rdata)
  );
  assign sen_rd = sen_rdata;

  assign cell_addr = LOG_AW'(row_q) * LOG_AW'(GRID_SIDE) + LOG_AW'(col_q);
  assign log_wdata = 32'(~mag_q + 32'd1);

  glsl_ram #(.WIDTH(32), .DEPTH(LOG_D)) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == C_WR),
    .waddr_i (cell_addr),
    .wdata_i (log_wdata),
    .raddr_i (cell_addr),
    .rdata_o (log_rdata)
  );

  // ---- datapath -------------------------------------------------------------
  logic signed [17:0] dx, dy, diff;
  logic [16:0]        adx, ady;
  logic [17:0]        ad;
  logic [MUL_W-1:0]   op_a, op_b;

  assign dx   = $signed({3'b000, col_q, 8'h00}) - 18'(sen_rd.x);
  assign dy   = $signed({4'b0000, row_q, 8'h00}) - 18'(sen_rd.y);
  assign adx  = dx[17] ? 17'(-dx) : dx[16:0];
  assign ady  = dy[17] ? 17'(-dy) : dy[16:0];
  assign diff = $signed(d_q) - $signed({2'b00, sen_rd.rng});
  assign ad   = diff[17] ? 18'(-diff) : 18'(diff);

  always_comb begin
    unique case (state_q)
      C_DX:    begin op_a = MUL_W'(adx);        op_b = MUL_W'(adx); end
      C_DY:    begin op_a = MUL_W'(ady);        op_b = MUL_W'(ady); end
      C_AD:    begin op_a = MUL_W'(ad);         op_b = MUL_W'(ad); end
      C_SP:    begin op_a = MUL_W'(sen_rd.spr); op_b = MUL_W'(sen_rd.spr); end
      N_MUL:   begin op_a = t_q;                op_b = MUL_W'(f_q); end
      N_RCP:   begin op_a = t_q;                op_b = recip_mul(k_q); end
      N_FIN:   begin op_a = acc_q;              op_b = exp_int_q24(n_q); end
      default: begin op_a = '0;                 op_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
  end

  // quotient of the series term by its index
  logic [24:0] term;
  assign term = 25'(prod_q >> (6'd24 + 6'(recip_shift(k_q))));

  logic              sq_done, div_done, div_start;
  logic [ROOT_W-1:0] root;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den;

  glsl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == C_SQ),
    .rad_i   (SQ_W'(dx2_q) + SQ_W'(prod_q[31:0])),
    .done_o  (sq_done),
    .root_o  (root)
  );

  assign div_start = state_q == C_DIV;
  assign div_num   = {ad2_q[32:0], 16'h0000};
  assign div_den   = {prod_q[31:0], 1'b0};

  glsl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // saturating magnitude sum
  logic [32:0] mag_sum;
  logic [31:0] mag_next;
  assign mag_sum  = {1'b0, mag_q} + 33'(div_quot[30:0]);
  assign mag_next = (div_quot[DIV_NW-1:31] != '0 || mag_sum >= 33'h0_8000_0000) ?
                    32'h8000_0000 : mag_sum[31:0];

  logic signed [32:0] delta;
  logic signed [31:0] lg;
  assign lg    = log_rdata;
  assign delta = 33'(peak_q) - 33'(lg);

  logic last_col;
  assign last_col = (col_q + DIM_W'(1)) == cols;

  // ---- sequencer ------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      peak_q      <= 32'sh8000_0000;
      peak_col_q  <= '0;
      peak_row_q  <= '0;
      s_q         <= '0;
      col_q       <= '0;
      row_q       <= '0;
      res_valid_q <= 1'b0;
      kind_q      <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            row_q <= row_i;
            col_q <= '0;
            unique case (mode_e'(mode_i))
              MODE_LOAD: begin
                if (first_sensor_i) begin
                  count_q    <= CNT_W'(1);
                  peak_q     <= 32'sh8000_0000;
                  peak_col_q <= '0;
                  peak_row_q <= '0;
                end else if (load_ok) begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              MODE_COMPUTE: if (DIM_W'(row_i) < rows) state_q <= C_CELL;
              MODE_READ:    if (DIM_W'(row_i) < rows) state_q <= N_RD;
              MODE_ARGMAX: begin
                res_valid_q <= 1'b1;
                kind_q      <= 1'b1;
                last_q      <= 1'b1;
                res_col_q   <= peak_col_q;
                res_row_q   <= peak_row_q;
                res_prob_q  <= 17'h1_0000;
                res_peak_q  <= peak_q;
              end
              default: ;
            endcase
          end
        end
        C_CELL: begin
          mag_q   <= '0;
          s_q     <= '0;
          state_q <= (count_q == '0) ? C_WR : C_RD;
        end
        C_RD: state_q <= C_DX;
        C_DX: state_q <= C_DY;
        C_DY: begin
          dx2_q   <= prod_q[31:0];
          state_q <= C_SQ;
        end
        C_SQ: state_q <= C_SQW;
        C_SQW: if (sq_done) begin
          d_q     <= root;
          state_q <= C_AD;
        end
        C_AD: state_q <= C_SP;
        C_SP: begin
          ad2_q   <= prod_q[32:0];
          state_q <= C_DIV;
        end
        C_DIV: state_q <= C_DIVW;
        C_DIVW: if (div_done) begin
          mag_q   <= mag_next;
          s_q     <= s_q + CNT_W'(1);
          state_q <= (s_q + CNT_W'(1) == count_q) ? C_WR : C_RD;
        end
        C_WR: begin
          if ($signed(log_wdata) > peak_q) begin
            peak_q     <= log_wdata;
            peak_col_q <= col_q[5:0];
            peak_row_q <= row_q;
          end
          col_q   <= col_q + DIM_W'(1);
          state_q <= last_col ? S_IDLE : C_CELL;
        end
        N_RD: state_q <= N_EVAL;
        N_EVAL: begin
          acc_q <= 25'h100_0000;
          t_q   <= 25'h100_0000;
          k_q   <= 4'd1;
          f_q   <= {delta[15:0], 8'h00};
          n_q   <= delta[19:16];
          priority if (delta <= 33'sd0) begin
            prob_q  <= 17'h1_0000;
            state_q <= N_OUT;
          end else if (delta[32:16] >= 17'(EXP_N)) begin
            prob_q  <= '0;
            state_q <= N_OUT;
          end else begin
            state_q <= N_MUL;
          end
        end
        N_MUL: state_q <= N_QX;
        N_QX: begin
          t_q     <= prod_q[48:24];
          state_q <= N_RCP;
        end
        N_RCP: state_q <= N_ACC;
        N_ACC: begin
          t_q   <= term;
          acc_q <= k_q[0] ? (acc_q - term) : (acc_q + term);
          k_q   <= k_q + 4'd1;
          state_q <= (k_q == 4'(SERIES_N)) ? N_FIN : N_MUL;
        end
        N_FIN: state_q <= N_RND;
        N_RND: begin
          prob_q  <= 17'((prod_q[48:24] + 25'd128) >> 8);
          state_q <= N_OUT;
        end
        N_OUT: begin
          res_valid_q <= 1'b1;
          kind_q      <= 1'b0;
          last_q      <= last_col;
          res_col_q   <= col_q[5:0];
          res_row_q   <= row_q;
          res_prob_q  <= prob_q;
          res_peak_q  <= peak_q;
          col_q       <= col_q + DIM_W'(1);
          state_q     <= last_col ? S_IDLE : N_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = state_q != S_IDLE;
  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign column_o       = res_col_q;
  assign row_index_o    = res_row_q;
  assign probability_o  = res_prob_q;
  assign peak_log_o     = res_peak_q;
  assign last_o         = last_q;

  // ---- assertions -----------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SENSORS))
    else $error("sensor count above capacity");

  a_cell_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !kind_o) |-> $past(busy_o))
    else $error("cell result without a read in progress");

  a_last_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !kind_o && last_o) |-> (DIM_W'(column_o) + DIM_W'(1) == cols))
    else $error("last flag not on final column");

  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (probability_o <= 17'h1_0000))
    else $error("probability above one");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid likelihood source locator.
// A built-in predictor tracks the sensor list, the log store and the peak.
// Every result strobe is compared against the oldest predicted result.
// Directed requests cover field extremes, register clamping, a full sensor
// list, and reads above a cleared peak. Random phases follow, each one
// loading sensors, computing rows and reading them back.
// ----------------------------------------------------------------------------
module tb;
  import glsl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SENSOR_CAP = 16;
  localparam int unsigned SIDE       = 64;

  typedef struct {
    logic        kind;
    logic [5:0]  column;
    logic [5:0]  row_index;
    logic [16:0] probability;
    logic [31:0] peak_log;
    logic        last;
  } cell_result_t;

  localparam longint unsigned EXP_STEP [12] = '{
    16777216, 6171993, 2270549, 835288, 307285, 113044,
    41587, 15299, 5628, 2070, 762, 280
  };

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         mode_i;
  logic signed [15:0] sensor_x_i;
  logic signed [15:0] sensor_y_i;
  logic [15:0]        sensor_range_i;
  logic [15:0]        sensor_spread_i;
  logic               first_sensor_i;
  logic [5:0]         row_i;
  logic               cfg_we_i;
  logic [0:0]         cfg_idx_i;
  logic [6:0]         cfg_data_i;
  logic               result_valid_o;
  logic               kind_o;
  logic [5:0]         column_o;
  logic [5:0]         row_index_o;
  logic [16:0]        probability_o;
  logic signed [31:0] peak_log_o;
  logic               last_o;

  grid_likelihood_source_locator u_dut (.*);

  // predictor state
  int          sens_x   [SENSOR_CAP];
  int          sens_y   [SENSOR_CAP];
  int unsigned sens_rng [SENSOR_CAP];
  int unsigned sens_spr [SENSOR_CAP];
  int unsigned sens_count;
  int          log_mem  [SIDE*SIDE];
  bit          computed [SIDE*SIDE];
  int          peak_val;
  int unsigned peak_col, peak_row;
  int unsigned grid_cols_raw, grid_rows_raw;

  cell_result_t expected_cells[$];
  int          n_errors, n_requests, n_results, n_cfg_writes;
  bit          calm;
  bit          start_held;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned dim_eff(int unsigned v);
    if (v < 1) return 1;
    if (v > SIDE) return SIDE;
    return v;
  endfunction

  function automatic longint unsigned isqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int cell_loglik(int unsigned col, int unsigned rw);
    longint unsigned mag, d, ad, sp;
    longint dx, dy, diff;
    mag = 0;
    for (int unsigned s = 0; s < sens_count; s++) begin
      dx   = longint'(col) * 256 - sens_x[s];
      dy   = longint'(rw) * 256 - sens_y[s];
      d    = isqrt_floor(longint'(dx * dx) + longint'(dy * dy));
      diff = longint'(d) - longint'(sens_rng[s]);
      ad   = (diff < 0) ? -diff : diff;
      sp   = sens_spr[s];
      mag  = mag + ((ad * ad) << 16) / (2 * sp * sp);
    end
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    return int'(-longint'(mag));
  endfunction

  function automatic logic [16:0] normalized_prob(int lg);
    longint delta, acc;
    longint unsigned n, f, t;
    delta = longint'(peak_val) - longint'(lg);
    if (delta <= 0) return 17'd65536;
    n = delta >> 16;
    if (n >= 12) return 17'd0;
    f   = (delta & 64'hFFFF) << 8;
    acc = 64'd1 << 24;
    t   = 64'd1 << 24;
    for (int k = 1; k <= 11; k++) begin
      t = ((t * f) >> 24) / k;
      if (k % 2 == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    t = (longint'(acc) * EXP_STEP[n]) >> 24;
    return 17'((t + 128) >> 8);
  endfunction

  // advance the predictor by one accepted request
  task automatic predict_request(mode_e md, int sx, int sy, int unsigned rng,
                                 int unsigned spr, bit first, int unsigned rw);
    cell_result_t e;
    int unsigned  cols, rows;
    int           lg;
    cols = dim_eff(grid_cols_raw);
    rows = dim_eff(grid_rows_raw);
    case (md)
      MODE_LOAD: begin
        if (first) begin
          sens_count = 0;
          peak_val   = 32'h8000_0000;
          peak_col   = 0;
          peak_row   = 0;
        end
        if (sens_count < SENSOR_CAP) begin
          sens_x[sens_count]   = sx;
          sens_y[sens_count]   = sy;
          sens_rng[sens_count] = rng;
          sens_spr[sens_count] = (spr == 0) ? 1 : spr;
          sens_count++;
        end
      end
      MODE_ARGMAX: begin
        e = '{1'b1, 6'(peak_col), 6'(peak_row), 17'd65536, peak_val, 1'b1};
        expected_cells.push_back(e);
      end
      MODE_COMPUTE: begin
        if (rw < rows) begin
          for (int unsigned c = 0; c < cols; c++) begin
            lg = cell_loglik(c, rw);
            log_mem[rw*SIDE + c]  = lg;
            computed[rw*SIDE + c] = 1'b1;
            if (lg > peak_val) begin
              peak_val = lg;
              peak_col = c;
              peak_row = rw;
            end
          end
        end
      end
      default: begin
        if (rw < rows) begin
          for (int unsigned c = 0; c < cols; c++) begin
            e = '{1'b0, 6'(c), 6'(rw), normalized_prob(log_mem[rw*SIDE + c]),
                  peak_val, (c + 1 == cols)};
            expected_cells.push_back(e);
          end
        end
      end
    endcase
  endtask

  // drive one request and hold it until accepted
  task automatic send_request(mode_e md, int sx = 0, int sy = 0, int unsigned rng = 0,
                              int unsigned spr = 1, bit first = 0, int unsigned rw = 0);
    int unsigned gap;
    start_i         <= 1'b1;
    mode_i          <= md;
    sensor_x_i      <= 16'(sx);
    sensor_y_i      <= 16'(sy);
    sensor_range_i  <= 16'(rng);
    sensor_spread_i <= 16'(spr);
    first_sensor_i  <= first;
    row_i           <= 6'(rw);
    start_held = 1'b1;
    do @(posedge clk_i); while (busy_o);
    predict_request(md, 32'(signed'(16'(sx))), 32'(signed'(16'(sy))),
                    rng & 16'hFFFF, spr & 16'hFFFF, first, rw & 6'h3F);
    n_requests++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start_i <= 1'b0;
      start_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic release_request();
    if (start_held) start_i <= 1'b0;
    start_held = 1'b0;
  endtask

  task automatic drain_results();
    release_request();
    do @(posedge clk_i); while (expected_cells.size() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_grid(int unsigned cols, int unsigned rows);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_GRID_COLUMNS;
    cfg_data_i <= 7'(cols);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GRID_ROWS;
    cfg_data_i <= 7'(rows);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_cols_raw = cols & 7'h7F;
    grid_rows_raw = rows & 7'h7F;
    n_cfg_writes += 2;
  endtask

  function automatic bit row_readable(int unsigned rw);
    for (int unsigned c = 0; c < dim_eff(grid_cols_raw); c++)
      if (!computed[rw*SIDE + c]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic load_random_sensor(bit first, bit wide);
    if (wide)
      send_request(MODE_LOAD, $urandom_range(0, 65535) - 32768,
                   $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535),
                   $urandom_range(0, 65535), first);
    else
      send_request(MODE_LOAD, $urandom_range(0, 2048) - 256, $urandom_range(0, 2048) - 256,
                   $urandom_range(0, 1536), $urandom_range(0, 7) == 0 ? 0 :
                   $urandom_range(64, 1024), first);
  endtask

  // result checker
  always @(posedge clk_i) begin
    cell_result_t e;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (expected_cells.size() == 0) begin
        $error("unexpected result: column %0d row %0d", column_o, row_index_o);
        n_errors++;
      end else begin
        e = expected_cells.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, kind_o); n_errors++;
        end
        if (column_o !== e.column) begin
          $error("column: expected %0d actual %0d", e.column, column_o); n_errors++;
        end
        if (row_index_o !== e.row_index) begin
          $error("row_index: expected %0d actual %0d", e.row_index, row_index_o);
          n_errors++;
        end
        if (probability_o !== e.probability) begin
          $error("probability: expected %0d actual %0d", e.probability, probability_o);
          n_errors++;
        end
        if (peak_log_o !== e.peak_log) begin
          $error("peak_log: expected %0d actual %0d", $signed(e.peak_log), peak_log_o);
          n_errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, last_o); n_errors++;
        end
      end
    end
  end

  task automatic test_reset_argmax();
    send_request(MODE_ARGMAX);
  endtask

  task automatic test_extremes();
    write_grid(0, 127);
    send_request(MODE_LOAD, -32768, 32767, 65535, 0, 1);
    send_request(MODE_COMPUTE, .rw(63));
    send_request(MODE_COMPUTE, .rw(0));
    send_request(MODE_READ, .rw(63));
    send_request(MODE_READ, .rw(0));
    send_request(MODE_ARGMAX);
    write_grid(127, 64);
    send_request(MODE_LOAD, 32767, -32768, 0, 65535, 1);
    send_request(MODE_LOAD, 20 * 256, 63 * 256, 512, 256, 0);
    send_request(MODE_COMPUTE, .rw(63));
    send_request(MODE_READ, .rw(63));
    send_request(MODE_ARGMAX);
  endtask

  task automatic test_clear_above_peak();
    // logs stored under the old peak read back above the cleared one
    send_request(MODE_LOAD, 256, 256, 128, 512, 1);
    send_request(MODE_READ, .rw(63));
    send_request(MODE_ARGMAX);
  endtask

  task automatic test_full_list();
    write_grid(2, 2);
    for (int i = 0; i < 17; i++)
      send_request(MODE_LOAD, $urandom_range(0, 512), $urandom_range(0, 512),
                   $urandom_range(0, 400), $urandom_range(128, 512), i == 0);
    send_request(MODE_COMPUTE, .rw(0));
    send_request(MODE_COMPUTE, .rw(1));
    send_request(MODE_COMPUTE, .rw(2));
    send_request(MODE_READ, .rw(1));
    send_request(MODE_READ, .rw(0));
    send_request(MODE_READ, .rw(3));
    send_request(MODE_ARGMAX);
  endtask

  task automatic test_random_phases();
    int unsigned cols, rows, nsens, rw;
    while (n_requests < 290) begin
      if (n_requests > 240) calm = 1'b1;
      cols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      write_grid(cols, rows);
      nsens = $urandom_range(1, 3);
      for (int i = 0; i < nsens; i++)
        load_random_sensor(i == 0 && (sens_count > 5 || $urandom_range(0, 4) != 0),
                           $urandom_range(0, 5) == 0);
      for (int unsigned r = 0; r < dim_eff(grid_rows_raw); r++)
        send_request(MODE_COMPUTE, .rw(r));
      if ($urandom_range(0, 2) == 0)
        send_request(MODE_COMPUTE, .rw($urandom_range(dim_eff(grid_rows_raw), 63)));
      repeat ($urandom_range(1, 3)) begin
        rw = $urandom_range(0, dim_eff(grid_rows_raw) - 1);
        if (row_readable(rw)) send_request(MODE_READ, .rw(rw));
      end
      if ($urandom_range(0, 2) == 0)
        send_request(MODE_READ, .rw($urandom_range(dim_eff(grid_rows_raw), 63)));
      send_request(MODE_ARGMAX);
      // now and then, hold off until every pending result is out
      if ($urandom_range(0, 3) == 0) drain_results();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    mode_i          = MODE_LOAD;
    sensor_x_i      = '0;
    sensor_y_i      = '0;
    sensor_range_i  = '0;
    sensor_spread_i = 16'd1;
    first_sensor_i  = 1'b0;
    row_i           = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_GRID_COLUMNS;
    cfg_data_i      = '0;
    sens_count      = 0;
    peak_val        = 32'h8000_0000;
    peak_col        = 0;
    peak_row        = 0;
    grid_cols_raw   = SIDE;
    grid_rows_raw   = SIDE;
    foreach (computed[i]) computed[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_argmax();
    test_extremes();
    test_clear_above_peak();
    test_full_list();
    test_random_phases();

    drain_results();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d requests over %0d register writes, %0d results checked",
             n_requests, n_cfg_writes, n_results);
    if (n_errors == 0 && expected_cells.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/glsl_pkg.sv
design/glsl_ram.sv
design/glsl_div.sv
design/glsl_sqrt.sv
design/grid_likelihood_source_locator.sv
tb/tb.sv
